[sv/assert_macros.svh]
// Assertion helpers for the RTL files; only rbol_datapath includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Property that must hold at every clock edge outside reset.
`define RBOL_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Condition that must never be seen outside reset.
`define RBOL_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);

`else

`define RBOL_ASSERT(lbl, clk, rstn, prop, msg)
`define RBOL_NEVER(lbl, clk, rstn, cond, msg)

`endif

`endif

[sv/rbol_pkg.sv]
package rbol_pkg;

  // Field widths of the request and response words.
  localparam int unsigned HANDLE_W  = 32;
  localparam int unsigned SIZE_W    = 16;
  localparam int unsigned OFFSET_W  = 20;
  localparam int unsigned SLOT_W    = 4;
  // The running sum never passes the offset before a hit, so one extra bit covers it.
  localparam int unsigned ACC_W     = OFFSET_W + 1;
  localparam int unsigned ENTRY_W   = HANDLE_W + SIZE_W;

  localparam int unsigned RING_DEPTH_DEF = 16;

  // Request codes.
  localparam logic REQ_ADD  = 1'b0;
  localparam logic REQ_FIND = 1'b1;

  typedef struct packed {
    logic                req_type;
    logic [HANDLE_W-1:0] entry_handle;
    logic [SIZE_W-1:0]   entry_size;
    logic [OFFSET_W-1:0] find_offset;
  } req_t;

  typedef struct packed {
    logic                found;
    logic [SLOT_W-1:0]   slot_index;
    logic [HANDLE_W-1:0] handle_out;
    logic [SIZE_W-1:0]   byte_in_entry;
  } rsp_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic add;    // store the request word as a new entry
    logic start;  // begin a walk for the request word
    logic step;   // advance the walk by one entry
    logic load;   // capture the walk outcome in the response register
  } dp_cmd_t;

  // Walk status from the datapath.
  typedef struct packed {
    logic hit;   // the entry under compare covers the offset
    logic miss;  // every stored entry was checked without a hit
  } dp_sts_t;

  typedef enum logic {
    ST_IDLE,
    ST_WALK
  } ctl_state_e;

endpackage

[sv/rbol_ram.sv]
module rbol_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port; the data holds while no read is issued.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[sv/rbol_datapath.sv]
`include "assert_macros.svh"

module rbol_datapath import rbol_pkg::*; #(
  parameter int unsigned RING_DEPTH = RING_DEPTH_DEF
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  req_t    req_i,
  input  dp_cmd_t cmd_i,
  output dp_sts_t sts_o,
  output rsp_t    rsp_o
);

  localparam int unsigned PTR_W = $clog2(RING_DEPTH);
  localparam int unsigned CNT_W = $clog2(RING_DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(RING_DEPTH - 1);

  logic [PTR_W-1:0]    wp_q, rp_q, rd_ptr_q, pend_slot_q;
  logic                full_q, pend_q;
  logic [CNT_W-1:0]    left_q, count;
  logic [ACC_W-1:0]    acc_q, off_q, acc_sum;
  logic [PTR_W-1:0]    wp_next, rd_ptr_next;
  logic [ENTRY_W-1:0]  rd_entry;
  logic [HANDLE_W-1:0] rd_handle;
  logic [SIZE_W-1:0]   rd_size;
  logic [PTR_W+SLOT_W-1:0] slot_ext;
  logic                hit, issue;
  rsp_t                rsp_q;

  // Pointer increments with wrap at the ring depth.
  assign wp_next     = (wp_q == LAST_SLOT) ? '0 : wp_q + 1'b1;
  assign rd_ptr_next = (rd_ptr_q == LAST_SLOT) ? '0 : rd_ptr_q + 1'b1;

  // Number of stored entries.
  always_comb begin
    if (full_q) begin
      count = CNT_W'(RING_DEPTH);
    end else if (wp_q >= rp_q) begin
      count = CNT_W'(wp_q) - CNT_W'(rp_q);
    end else begin
      count = CNT_W'(wp_q) + CNT_W'(RING_DEPTH) - CNT_W'(rp_q);
    end
  end

  // Entry memory: handle in the upper bits, size in the lower bits.
  assign issue = cmd_i.step && (left_q != '0);

  rbol_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (RING_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.add),
    .waddr_i (wp_q),
    .wdata_i ({req_i.entry_handle, req_i.entry_size}),
    .re_i    (issue),
    .raddr_i (rd_ptr_q),
    .rdata_o (rd_entry)
  );

  assign rd_handle = rd_entry[ENTRY_W-1:SIZE_W];
  assign rd_size   = rd_entry[SIZE_W-1:0];

  // Compare the running sum plus the fetched size against the offset.
  assign acc_sum = acc_q + ACC_W'(rd_size);
  assign hit     = pend_q && (acc_sum > off_q);

  assign sts_o.hit  = hit;
  assign sts_o.miss = !pend_q && (left_q == '0);

  // Ring pointers and full flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q   <= '0;
      rp_q   <= '0;
      full_q <= 1'b0;
    end else if (cmd_i.add) begin
      wp_q <= wp_next;
      if (full_q) begin
        rp_q <= wp_next;
      end else if (wp_next == rp_q) begin
        full_q <= 1'b1;
      end
    end
  end

  // Walk state: read address, entries left to fetch, running sum.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_ptr_q    <= '0;
      pend_slot_q <= '0;
      left_q      <= '0;
      pend_q      <= 1'b0;
      acc_q       <= '0;
      off_q       <= '0;
    end else if (cmd_i.start) begin
      rd_ptr_q <= rp_q;
      left_q   <= count;
      pend_q   <= 1'b0;
      acc_q    <= '0;
      off_q    <= ACC_W'(req_i.find_offset);
    end else if (cmd_i.step) begin
      if (issue) begin
        rd_ptr_q    <= rd_ptr_next;
        pend_slot_q <= rd_ptr_q;
        left_q      <= left_q - 1'b1;
        pend_q      <= 1'b1;
      end else begin
        pend_q <= 1'b0;
      end
      if (pend_q && !hit) begin
        acc_q <= acc_sum;
      end
    end
  end

  // Response register, zero fields on a miss.
  assign slot_ext = {{SLOT_W{1'b0}}, pend_slot_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      rsp_q.found <= hit;
      if (hit) begin
        rsp_q.slot_index    <= slot_ext[SLOT_W-1:0];
        rsp_q.handle_out    <= rd_handle;
        rsp_q.byte_in_entry <= SIZE_W'(off_q - acc_q);
      end else begin
        rsp_q.slot_index    <= '0;
        rsp_q.handle_out    <= '0;
        rsp_q.byte_in_entry <= '0;
      end
    end
  end

  assign rsp_o = rsp_q;

  `RBOL_NEVER(a_hit_and_miss, clk_i, rst_ni, hit && sts_o.miss, "hit and miss together")
  `RBOL_ASSERT(a_full_ptrs, clk_i, rst_ni, full_q |-> (wp_q == rp_q), "pointers apart when full")
  `RBOL_ASSERT(a_acc_bound, clk_i, rst_ni, acc_q <= off_q, "running sum passed the offset")

endmodule

[sv/rbol_ctrl.sv]
module rbol_ctrl import rbol_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  input  logic    req_type_i,
  output logic    in_ready_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  input  dp_sts_t sts_i,
  output dp_cmd_t cmd_o
);

  ctl_state_e state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       out_busy, finish;

  assign out_busy = out_valid_q && !out_ready_i;
  assign finish   = sts_i.hit || sts_i.miss;

  // State and output-valid registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Next state and datapath commands.
  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_d = out_valid_q && !out_ready_i;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (req_type_i == REQ_FIND) begin
            cmd_o.start = 1'b1;
            state_d     = ST_WALK;
          end else begin
            cmd_o.add = 1'b1;
          end
        end
      end
      ST_WALK: begin
        // Hold the walk when its outcome cannot be placed in the response register.
        if (!(finish && out_busy)) begin
          cmd_o.step = 1'b1;
          if (finish) begin
            cmd_o.load  = 1'b1;
            out_valid_d = 1'b1;
            state_d     = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule

[sv/ring_buffer_offset_locator.sv]
// Ring of buffer entries (handle and byte size) with overwrite of the oldest.
// Input channel in_valid_i/in_ready_o carries one request word: an add stores
// an entry at the write pointer and gives no response; a find looks up the
// entry covering a byte offset in the stored data, oldest entry first.
// Output channel out_valid_o/out_ready_i carries one response word per find:
// found flag, ring slot, handle and byte position within the entry.
// An add is stored when it is accepted and leaves the block ready. A find walks
// the stored entries through the single read port of the entry memory, one
// entry per cycle: each entry is read, then its size is added to the running
// sum and compared with the offset, until a hit or the last entry. The next
// request is accepted in the cycle after the response is loaded.
// The response sits in an output register, so new requests are accepted while
// it waits; a walk that finishes while the previous response is still
// stalled holds until the receiver takes it.
// Reset empties the ring (pointers and full flag cleared); entry contents are
// not cleared and are only read after being written.
module ring_buffer_offset_locator import rbol_pkg::*; #(
  parameter int unsigned RING_DEPTH = RING_DEPTH_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  req_t in_word_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output rsp_t out_word_o
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  // Sequencer for adds and find walks.
  rbol_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .req_type_i  (in_word_i.req_type),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Ring pointers, entry memory and offset accumulation.
  rbol_datapath #(
    .RING_DEPTH (RING_DEPTH)
  ) u_datapath (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (in_word_i),
    .cmd_i  (cmd),
    .sts_o  (sts),
    .rsp_o  (out_word_o)
  );

endmodule

[verif/tb_ring_buffer_offset_locator.sv]
module tb_ring_buffer_offset_locator;
  import rbol_pkg::*;

  localparam int unsigned DEPTH     = RING_DEPTH_DEF;
  localparam int unsigned MAX_OFS   = (1 << OFFSET_W) - 1;
  localparam int unsigned MAX_SIZE  = (1 << SIZE_W) - 1;
  localparam int unsigned SETTLE    = DEPTH + 8;
  localparam int unsigned TAIL_LEN  = 150;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic req_valid = 1'b0;
  logic req_ready;
  req_t req_word = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  rsp_t rsp_word;

  // Words waiting to be sent, and responses expected from accepted finds.
  req_t pending[$];
  rsp_t rsp_due[$];

  // Shadow of the ring, updated when a word is accepted.
  logic [HANDLE_W-1:0] slot_handle[DEPTH];
  logic [SIZE_W-1:0]   slot_size[DEPTH];
  int unsigned wr_ptr = 0;
  int unsigned rd_ptr = 0;
  bit ring_full = 1'b0;

  // Sizes of the last DEPTH entries that the generator has queued, oldest first.
  int unsigned gen_sizes[$];

  int err_count = 0;
  int send_gap = 0;
  int stall_left = 0;
  bit quiet = 1'b0;

  ring_buffer_offset_locator #(
    .RING_DEPTH(DEPTH)
  ) u_top (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (req_valid),
    .in_ready_o (req_ready),
    .in_word_i  (req_word),
    .out_valid_o(rsp_valid),
    .out_ready_i(rsp_ready),
    .out_word_o (rsp_word)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic flag_mismatch(input string what);
    $display("MISMATCH at %0t: %s", $time, what);
    err_count++;
  endtask

  // Write an entry at the write pointer; a full ring drops its oldest entry.
  function automatic void store_entry(input logic [HANDLE_W-1:0] h,
                                      input logic [SIZE_W-1:0] s);
    int unsigned nxt;
    slot_handle[wr_ptr] = h;
    slot_size[wr_ptr] = s;
    nxt = (wr_ptr + 1) % DEPTH;
    wr_ptr = nxt;
    if (ring_full) begin
      rd_ptr = nxt;
    end else if (nxt == rd_ptr) begin
      ring_full = 1'b1;
    end
  endfunction

  // Walk the stored entries oldest first and find the one covering the offset.
  function automatic rsp_t lookup_offset(input logic [OFFSET_W-1:0] ofs);
    rsp_t r;
    int unsigned cnt;
    int unsigned acc;
    int unsigned slot;
    int unsigned i;
    r = '0;
    acc = 0;
    cnt = ring_full ? DEPTH : (wr_ptr + DEPTH - rd_ptr) % DEPTH;
    for (i = 0; i < cnt; i++) begin
      slot = (rd_ptr + i) % DEPTH;
      if (acc + slot_size[slot] > ofs) begin
        r.found = 1'b1;
        r.slot_index = SLOT_W'(slot);
        r.handle_out = slot_handle[slot];
        r.byte_in_entry = SIZE_W'(ofs - acc);
        return r;
      end
      acc += slot_size[slot];
    end
    return r;
  endfunction

  function automatic void apply_request(input req_t w);
    if (w.req_type == REQ_ADD) begin
      store_entry(w.entry_handle, w.entry_size);
    end else begin
      rsp_due.push_back(lookup_offset(w.find_offset));
    end
  endfunction

  task automatic check_response(input rsp_t got);
    rsp_t exp;
    if (rsp_due.size() == 0) begin
      flag_mismatch("response word with no find outstanding");
    end else begin
      exp = rsp_due.pop_front();
      if (got.found !== exp.found)
        flag_mismatch($sformatf("found %0b, expected %0b", got.found, exp.found));
      if (got.slot_index !== exp.slot_index)
        flag_mismatch($sformatf("slot_index %0d, expected %0d",
                                got.slot_index, exp.slot_index));
      if (got.handle_out !== exp.handle_out)
        flag_mismatch($sformatf("handle_out %h, expected %h",
                                got.handle_out, exp.handle_out));
      if (got.byte_in_entry !== exp.byte_in_entry)
        flag_mismatch($sformatf("byte_in_entry %0d, expected %0d",
                                got.byte_in_entry, exp.byte_in_entry));
    end
  endtask

  // Request driver: predicts each accepted word, then offers the next one.
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      req_valid <= 1'b0;
      req_word <= '0;
      send_gap = 0;
    end else begin
      if (req_valid && req_ready) apply_request(req_word);
      if (!req_valid || req_ready) begin
        if (send_gap > 0) begin
          send_gap--;
          req_valid <= 1'b0;
        end else if (pending.size() != 0) begin
          req_valid <= 1'b1;
          req_word <= pending.pop_front();
          if (!quiet && $urandom_range(0, 5) == 0) send_gap = $urandom_range(1, 19);
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  // Response monitor: checks each accepted word and stalls in random bursts.
  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      rsp_ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (rsp_valid && rsp_ready) check_response(rsp_word);
      if (stall_left > 0) begin
        stall_left--;
        rsp_ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(0, 18);
        rsp_ready <= 1'b0;
      end else begin
        rsp_ready <= 1'b1;
      end
    end
  end

  function automatic req_t noise_word();
    req_t w;
    w.req_type = 1'($urandom_range(0, 1));
    w.entry_handle = $urandom();
    w.entry_size = SIZE_W'($urandom());
    w.find_offset = OFFSET_W'($urandom());
    return w;
  endfunction

  task automatic push_add(input logic [HANDLE_W-1:0] h, input logic [SIZE_W-1:0] s);
    req_t w;
    w = noise_word();
    w.req_type = REQ_ADD;
    w.entry_handle = h;
    w.entry_size = s;
    pending.push_back(w);
    gen_sizes.push_back(s);
    if (gen_sizes.size() > DEPTH) void'(gen_sizes.pop_front());
  endtask

  task automatic push_find(input logic [OFFSET_W-1:0] ofs);
    req_t w;
    w = noise_word();
    w.req_type = REQ_FIND;
    w.find_offset = ofs;
    pending.push_back(w);
  endtask

  function automatic logic [SIZE_W-1:0] pick_size();
    case ($urandom_range(0, 7))
      0:       return '0;
      1, 2, 3: return SIZE_W'($urandom_range(1, 64));
      4, 5:    return SIZE_W'($urandom_range(1, 4095));
      default: return SIZE_W'($urandom_range(0, MAX_SIZE));
    endcase
  endfunction

  // Pick an offset: mostly inside the stored data, with entry starts,
  // the end of the data and wild values mixed in.
  function automatic logic [OFFSET_W-1:0] pick_offset();
    int unsigned total;
    int unsigned start;
    int unsigned k;
    int unsigned i;
    total = 0;
    foreach (gen_sizes[j]) total += gen_sizes[j];
    case ($urandom_range(0, 9))
      0: return OFFSET_W'($urandom());
      1: return OFFSET_W'($urandom_range(total, MAX_OFS));
      2, 3: begin
        if (gen_sizes.size() == 0) return '0;
        k = $urandom_range(0, gen_sizes.size());
        start = 0;
        for (i = 0; i < k; i++) start += gen_sizes[i];
        if (start > 0 && $urandom_range(0, 1) == 1) start--;
        return OFFSET_W'(start);
      end
      default: return (total == 0) ? '0 : OFFSET_W'($urandom_range(0, total - 1));
    endcase
  endfunction

  task automatic wait_drained();
    while (pending.size() != 0 || req_valid || rsp_due.size() != 0) @(negedge clk);
  endtask

  // Stimulus: directed words, a full drain, then two random batches.
  initial begin
    int i;
    int b;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Empty ring answers not found for any offset.
    push_find('0);
    push_find(OFFSET_W'(MAX_OFS));
    // Largest entry, a zero-size entry, then a one-byte entry.
    push_add('1, SIZE_W'(MAX_SIZE));
    push_add('0, '0);
    push_add(32'ha5a5_5a5a, SIZE_W'(1));
    push_find('0);
    push_find(OFFSET_W'(MAX_SIZE - 1));
    // Lands past the zero-size entry on the one-byte entry.
    push_find(OFFSET_W'(MAX_SIZE));
    // Just past the stored data.
    push_find(OFFSET_W'(MAX_SIZE + 1));
    // Fill the ring with large entries, then overwrite the oldest.
    for (i = 0; i < DEPTH - 3; i++) push_add(HANDLE_W'(i + 1), SIZE_W'(MAX_SIZE));
    push_find(OFFSET_W'((DEPTH - 2) * MAX_SIZE));
    push_find(OFFSET_W'((DEPTH - 2) * MAX_SIZE + 1));
    push_add(32'h0000_ffff, SIZE_W'(MAX_SIZE));
    push_find('0);
    push_find(OFFSET_W'(MAX_OFS));

    // Hold the sender until every response is back.
    wait_drained();
    repeat (SETTLE) @(negedge clk);

    for (b = 0; b < 2; b++) begin
      for (i = 0; i < 900; i++) begin
        if ($urandom_range(0, 99) < 45) push_add($urandom(), pick_size());
        else push_find(pick_offset());
      end
      if (b == 0) begin
        wait_drained();
        repeat (SETTLE) @(negedge clk);
      end
    end

    // No idling on either side for the tail of the run.
    while (pending.size() > TAIL_LEN) @(negedge clk);
    quiet = 1'b1;
    wait_drained();
    repeat (SETTLE) @(negedge clk);
    if (rsp_due.size() != 0) flag_mismatch("expected responses never arrived");

    if (err_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #20_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
